/* rtl/core/circular_queue_buffer_assert.svh */
// ============================================================================
// circular_queue_buffer assertion macros
// Shorthand for clocked assertions that are disabled while reset is held.
// ============================================================================
`ifndef CIRCULAR_QUEUE_BUFFER_ASSERT_SVH
`define CIRCULAR_QUEUE_BUFFER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CQB_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("circular_queue_buffer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CQB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("circular_queue_buffer: next-cycle check failed");

`endif

/* rtl/core/cqb_pkg.sv */
// ============================================================================
// cqb_pkg
// Shared widths, codes and types of the circular queue buffer.
// ============================================================================
package cqb_pkg;

    localparam int DATA_W        = 32;
    localparam int ACTION_W      = 2;
    localparam int STATUS_W      = 2;
    localparam int DEPTH_DEFAULT = 8;
    // Result buffer at the output side.
    localparam int OBUF_DEPTH    = 4;

    // Request codes.
    localparam logic [ACTION_W-1:0] ACT_ENQ  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DEQ  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SHOW = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NOP  = 2'd3;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SHOW = 1'b1
    } t_state;

    typedef struct packed {
        t_status           status;
        logic [DATA_W-1:0] data;
        logic              last;
    } t_result;

endpackage

/* rtl/core/cqb_req_if.sv */
// ============================================================================
// cqb_req_if
// Request channel: one beat carries an action code and a word.
// ============================================================================
interface cqb_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [cqb_pkg::ACTION_W-1:0]          action;
    logic signed [cqb_pkg::DATA_W-1:0]     value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

/* rtl/core/cqb_rsp_if.sv */
// ============================================================================
// cqb_rsp_if
// Response channel: one beat carries a status, a word and an end marker.
// ============================================================================
interface cqb_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic [cqb_pkg::STATUS_W-1:0]          status;
    logic signed [cqb_pkg::DATA_W-1:0]     data;
    logic                                  last;

    modport source (output valid, output status, output data, output last, input ready);
    modport sink   (input valid, input status, input data, input last, output ready);
endinterface

/* rtl/core/cqb_ram.sv */
// ============================================================================
// cqb_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module cqb_ram #(
    parameter int WIDTH = cqb_pkg::DATA_W,
    parameter int DEPTH = cqb_pkg::DEPTH_DEFAULT,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/cqb_ctrl.sv */
// ============================================================================
// cqb_ctrl
// Queue controller: head and count registers, entry RAM access, display walk.
// ============================================================================
module cqb_ctrl #(
    parameter int DEPTH = cqb_pkg::DEPTH_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    cqb_req_if.sink          i_req,
    input  logic             i_space,
    output logic             o_push,
    output cqb_pkg::t_result o_res
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int DW    = cqb_pkg::DATA_W;

    cqb_pkg::t_state  r_state, n_state;
    logic [IDX_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_show_idx, n_show_idx;

    // Result waiting for the RAM read data.
    logic              r_pend_valid, n_pend_valid;
    logic              r_pend_use_rd, n_pend_use_rd;
    cqb_pkg::t_status  r_pend_status, n_pend_status;
    logic              r_pend_last, n_pend_last;
    logic [DW-1:0]     r_pend_data, n_pend_data;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [DW-1:0]    ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [DW-1:0]    ram_rdata;

    logic [SUM_W-1:0] w_tail_sum, w_tail_wrap;
    logic [SUM_W-1:0] w_show_sum, w_show_wrap;
    logic             w_full, w_empty, w_one;
    logic             w_accept, w_show_last;
    logic [IDX_W-1:0] w_head_inc;

    // Slot arithmetic: both sums stay below twice the depth.
    assign w_tail_sum  = SUM_W'(r_head) + SUM_W'(r_count);
    assign w_tail_wrap = (w_tail_sum >= SUM_W'(DEPTH)) ? w_tail_sum - SUM_W'(DEPTH)
                                                        : w_tail_sum;
    assign w_show_sum  = SUM_W'(r_head) + SUM_W'(r_show_idx);
    assign w_show_wrap = (w_show_sum >= SUM_W'(DEPTH)) ? w_show_sum - SUM_W'(DEPTH)
                                                        : w_show_sum;
    assign w_head_inc  = (r_head == IDX_W'(DEPTH - 1)) ? '0 : r_head + IDX_W'(1);

    assign w_full      = (r_count == CNT_W'(DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_one       = (r_count == CNT_W'(1));
    assign w_show_last = ((CNT_W'(r_show_idx) + CNT_W'(1)) == r_count);

    assign i_req.ready = (r_state == cqb_pkg::S_IDLE) && i_space;
    assign w_accept    = i_req.valid && i_req.ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cqb_pkg::S_IDLE: begin
                if (w_accept && (i_req.action == cqb_pkg::ACT_SHOW) && !w_empty && !w_one) begin
                    n_state = cqb_pkg::S_SHOW;
                end
            end
            cqb_pkg::S_SHOW: begin
                if (i_space && w_show_last) begin
                    n_state = cqb_pkg::S_IDLE;
                end
            end
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        n_head        = r_head;
        n_count       = r_count;
        n_show_idx    = r_show_idx;
        ram_we        = 1'b0;
        ram_waddr     = w_tail_wrap[IDX_W-1:0];
        ram_wdata     = $unsigned(i_req.value);
        ram_raddr     = r_head;
        n_pend_valid  = 1'b0;
        n_pend_use_rd = 1'b0;
        n_pend_status = cqb_pkg::ST_OK;
        n_pend_last   = 1'b1;
        n_pend_data   = $unsigned(i_req.value);

        unique case (r_state)
            cqb_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (i_req.action)
                        cqb_pkg::ACT_ENQ: begin
                            n_pend_valid = 1'b1;
                            if (w_full) begin
                                n_pend_status = cqb_pkg::ST_FULL;
                                n_pend_data   = '0;
                            end else begin
                                ram_we  = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        cqb_pkg::ACT_DEQ: begin
                            n_pend_valid = 1'b1;
                            if (w_empty) begin
                                n_pend_status = cqb_pkg::ST_EMPTY;
                                n_pend_data   = '0;
                            end else begin
                                n_pend_use_rd = 1'b1;
                                n_count       = r_count - CNT_W'(1);
                                // An emptied queue restarts at slot zero.
                                n_head        = w_one ? '0 : w_head_inc;
                            end
                        end
                        cqb_pkg::ACT_SHOW: begin
                            n_pend_valid = 1'b1;
                            if (w_empty) begin
                                n_pend_status = cqb_pkg::ST_EMPTY;
                                n_pend_data   = '0;
                            end else begin
                                n_pend_use_rd = 1'b1;
                                n_pend_last   = w_one;
                                n_show_idx    = IDX_W'(1);
                            end
                        end
                        cqb_pkg::ACT_NOP: begin
                            n_pend_valid = 1'b0;
                        end
                    endcase
                end
            end
            cqb_pkg::S_SHOW: begin
                if (i_space) begin
                    n_pend_valid  = 1'b1;
                    n_pend_use_rd = 1'b1;
                    ram_raddr     = w_show_wrap[IDX_W-1:0];
                    n_pend_last   = w_show_last;
                    n_show_idx    = r_show_idx + IDX_W'(1);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= cqb_pkg::S_IDLE;
            r_head       <= '0;
            r_count      <= '0;
            r_show_idx   <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_count      <= n_count;
            r_show_idx   <= n_show_idx;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_use_rd <= n_pend_use_rd;
        r_pend_status <= n_pend_status;
        r_pend_last   <= n_pend_last;
        r_pend_data   <= n_pend_data;
    end

    cqb_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_push       = r_pend_valid;
    assign o_res.status = r_pend_status;
    assign o_res.data   = r_pend_use_rd ? ram_rdata : r_pend_data;
    assign o_res.last   = r_pend_last;

endmodule

/* rtl/core/circular_queue_buffer.sv */
// ============================================================================
// circular_queue_buffer
// Fixed-depth circular queue of signed 32-bit words with a buffered result port.
// ============================================================================
// Usage:
// Requests arrive on i_req as valid/ready beats carrying an action and a word.
// Enqueue stores the word and answers ok with the word echoed, or full.
// Dequeue answers the oldest word and removes it, or answers empty. Display
// answers every stored word from oldest to newest, one beat each, with last
// set on the final one; on an empty queue it answers a single empty beat.
// Action code 3 is accepted and answers nothing. Every other request answers
// on o_rsp, and last marks the final beat of each request.
// Path: a request's first result beat is formed as the entry RAM read and the
// result register are clocked together; the output buffer then registers it
// before the receiver can take it.
// Enqueue and dequeue sustain one request per cycle while the output buffer has
// room; a display holds the request port until its last entry is read, as the
// single RAM read port delivers one entry per cycle while the buffer has room.
// The entry RAM is written and read in separate cycles, so no forwarding is
// needed. Reset empties the queue at once; the RAM contents are not cleared.
// When the receiver stalls, up to four result beats collect in the output
// buffer. i_req.ready falls as soon as the beats held plus the one in flight
// would fill it, and no work is started until the receiver takes beats again.
// ============================================================================
module circular_queue_buffer #(
    parameter int DEPTH = cqb_pkg::DEPTH_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cqb_req_if.sink   i_req,
    cqb_rsp_if.source o_rsp
);

    `include "circular_queue_buffer_assert.svh"

    localparam int OBUF_DEPTH = cqb_pkg::OBUF_DEPTH;
    localparam int PTR_W      = $clog2(OBUF_DEPTH);
    localparam int OCC_W      = $clog2(OBUF_DEPTH + 1);
    localparam int SP_W       = OCC_W + 1;

    // Result beats coming out of the controller.
    logic             w_push;
    cqb_pkg::t_result w_res;
    logic             w_space;
    logic             w_pop;
    // A request beat that must answer with at least one result beat.
    logic             w_req_beat;

    // Output buffer holding finished result beats in order.
    cqb_pkg::t_result r_obuf [OBUF_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [OCC_W-1:0] r_occ, n_occ;
    cqb_pkg::t_result w_head;

    cqb_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_space (w_space),
        .o_push  (w_push),
        .o_res   (w_res)
    );

    // The controller may start a beat only if the buffer can take it together
    // with the beat already in flight. This keeps ready free of o_rsp.ready.
    assign w_space = ((SP_W'(r_occ) + SP_W'(w_push)) <= SP_W'(OBUF_DEPTH - 1));

    assign w_pop  = o_rsp.valid && o_rsp.ready;
    assign w_head = r_obuf[r_rd_ptr];

    assign w_req_beat = i_req.valid && i_req.ready && (i_req.action != cqb_pkg::ACT_NOP);

    assign o_rsp.valid  = (r_occ != '0);
    assign o_rsp.status = w_head.status;
    assign o_rsp.data   = $signed(w_head.data);
    assign o_rsp.last   = w_head.last;

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = w_pop  ? r_rd_ptr + PTR_W'(1) : r_rd_ptr;
        unique case ({w_push, w_pop})
            2'b10:   n_occ = r_occ + OCC_W'(1);
            2'b01:   n_occ = r_occ - OCC_W'(1);
            default: n_occ = r_occ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_occ    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_occ    <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_obuf[r_wr_ptr] <= w_res;
        end
    end

    // A beat never arrives at a full output buffer.
    `CQB_ASSERT_SAME(a_obuf_no_overflow, w_push, r_occ < OCC_W'(OBUF_DEPTH))
    // Every accepted request except the no-op yields a result beat next cycle.
    `CQB_ASSERT_NEXT(a_req_makes_beat, w_req_beat, w_push)
    // A full output buffer holds off new requests.
    `CQB_ASSERT_SAME(a_full_blocks_req, r_occ == OCC_W'(OBUF_DEPTH), !i_req.ready)

endmodule
